[rtl/ascd_pkg.sv]
package ascd_pkg;

  localparam logic [3:0] PH_START    = 4'd0;
  localparam logic [3:0] PH_HDR_HI   = 4'd1;
  localparam logic [3:0] PH_OPCODE   = 4'd2;
  localparam logic [3:0] PH_PARAM    = 4'd3;
  localparam logic [3:0] PH_OPERANDS = 4'd4;
  localparam logic [3:0] PH_MANY     = 4'd5;
  localparam logic [3:0] PH_B7_HEAD  = 4'd6;
  localparam logic [3:0] PH_B7_GROUP = 4'd7;
  localparam logic [3:0] PH_B7_TAIL  = 4'd8;

  localparam logic [2:0] CL_HDR_LO  = 3'd0;
  localparam logic [2:0] CL_HDR_HI  = 3'd1;
  localparam logic [2:0] CL_OPCODE  = 3'd2;
  localparam logic [2:0] CL_PARAM   = 3'd3;
  localparam logic [2:0] CL_OPERAND = 3'd4;
  localparam logic [2:0] CL_TERM    = 3'd5;

  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] PARAM_END    = 8'h80;
  localparam logic [5:0] FUNC_MAX     = 6'h16;
  localparam logic [5:0] FUNC_NO_ARGS = 6'h02;
  localparam logic [2:0] B7_HEAD_LEN  = 3'd5;
  localparam logic [2:0] B6_OPERANDS  = 3'd2;
  localparam logic [1:0] GROUP_LAST   = 2'd3;

  localparam logic [5:0] FN_06 = 6'h06;
  localparam logic [5:0] FN_09 = 6'h09;
  localparam logic [5:0] FN_0B = 6'h0B;
  localparam logic [5:0] FN_0D = 6'h0D;
  localparam logic [5:0] FN_0E = 6'h0E;
  localparam logic [5:0] FN_0F = 6'h0F;
  localparam logic [5:0] FN_11 = 6'h11;
  localparam logic [5:0] FN_13 = 6'h13;
  localparam logic [5:0] FN_14 = 6'h14;
  localparam logic [5:0] FN_15 = 6'h15;
  localparam logic [5:0] FN_16 = 6'h16;

  typedef struct packed {
    logic [3:0] phase;
    logic [5:0] held_opcode;
    logic [2:0] bytes_left;
    logic [5:0] groups_left;
    logic [1:0] group_position;
    logic [7:0] header_low_byte;
    logic       first_block;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [15:0] anim_length;
    logic        bad_opcode;
    logic        anim_end;
    logic        stream_end;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_START, held_opcode: 6'd0, bytes_left: 3'd0, groups_left: 6'd0,
    group_position: 2'd0, header_low_byte: 8'd0, first_block: 1'b1
  };

  function automatic logic [1:0] tail_count(input logic [3:0] nib);
    tail_count = (nib >= 4'd3) ? 2'd3 : nib[1:0];
  endfunction

endpackage

[rtl/ascd_classify.sv]
module ascd_classify import ascd_pkg::*; (
  input  parse_state_t state,
  input  logic [7:0]   script_byte,
  input  logic         stream_start,
  input  logic         stream_mode,
  output parse_state_t state_next,
  output result_t      result
);

  always_comb begin
    parse_state_t s;
    result_t      r;
    logic [7:0]   b;
    logic [2:0]   n;
    logic [1:0]   tail;
    s = state;
    b = script_byte;
    n = 3'd0;
    tail = tail_count(b[3:0]);
    r.byte_class = CL_OPERAND;
    r.anim_length = 16'd0;
    r.bad_opcode = 1'b0;
    r.anim_end = 1'b0;
    r.stream_end = 1'b0;

    if (stream_start) begin
      s.phase = PH_START;
      s.first_block = 1'b1;
    end

    if (s.phase == PH_START && !(stream_mode && s.first_block)) begin
      r.byte_class = CL_HDR_LO;
      s.header_low_byte = b;
      s.phase = PH_HDR_HI;
    end else if (s.phase == PH_HDR_HI) begin
      if (!stream_mode && s.header_low_byte == BYTE_FF && b == BYTE_FF) begin
        r.byte_class = CL_TERM;
        r.stream_end = 1'b1;
        s.phase = PH_START;
        s.first_block = 1'b1;
      end else begin
        r.byte_class = CL_HDR_HI;
        r.anim_length = {b, s.header_low_byte};
        s.phase = PH_OPCODE;
      end
    end else if (s.phase == PH_START || s.phase == PH_OPCODE) begin
      r.byte_class = CL_OPCODE;
      s.phase = PH_OPCODE;
      if (b == BYTE_FF) begin
        r.byte_class = CL_TERM;
        r.anim_end = 1'b1;
        s.phase = PH_START;
        s.first_block = 1'b0;
      end else if (b[7]) begin
        s.groups_left = b[5:0];
        if (b[5:0] != 6'd0) begin
          s.bytes_left = B7_HEAD_LEN;
          s.phase = PH_B7_HEAD;
        end
      end else if (b[6]) begin
        s.bytes_left = B6_OPERANDS;
        s.phase = PH_OPERANDS;
      end else if (b[5:0] > FUNC_MAX) begin
        r.bad_opcode = 1'b1;
        r.anim_end = 1'b1;
        s.phase = PH_START;
        s.first_block = 1'b0;
      end else if (b[5:0] > FUNC_NO_ARGS) begin
        s.held_opcode = b[5:0];
        s.phase = PH_PARAM;
      end
    end else begin
      case (s.phase)
        PH_PARAM: begin
          r.byte_class = CL_PARAM;
          case (s.held_opcode)
            FN_06:        n = b[7] ? 3'd3 : 3'd2;
            FN_09:        n = 3'd1;
            FN_0D, FN_0E: n = (b != 8'd0) ? 3'd1 : 3'd0;
            FN_0F:        n = b[7] ? 3'd1 : 3'd2;
            FN_11:        n = {1'b0, tail};
            FN_13:        n = b[7] ? 3'd0 : 3'd1;
            FN_14:        n = 3'd4;
            FN_15:        n = 3'd1;
            default:      n = 3'd0;
          endcase
          if (s.held_opcode == FN_0B) begin
            s.groups_left = {2'd0, b[3:0]};
            s.phase = (b[3:0] != 4'd0) ? PH_MANY : PH_OPCODE;
          end else if (s.held_opcode == FN_16 && stream_mode && b == PARAM_END) begin
            r.anim_end = 1'b1;
            r.stream_end = 1'b1;
            s.phase = PH_START;
            s.first_block = 1'b1;
          end else begin
            s.bytes_left = n;
            s.phase = (n != 3'd0) ? PH_OPERANDS : PH_OPCODE;
          end
        end
        PH_OPERANDS: begin
          s.bytes_left = s.bytes_left - 3'd1;
          if (s.bytes_left == 3'd0) s.phase = PH_OPCODE;
        end
        PH_MANY: begin
          s.groups_left = s.groups_left - 6'd1;
          if (s.groups_left == 6'd0) s.phase = PH_OPCODE;
        end
        PH_B7_HEAD: begin
          s.bytes_left = s.bytes_left - 3'd1;
          if (s.bytes_left == 3'd0) begin
            s.group_position = 2'd0;
            s.phase = PH_B7_GROUP;
          end
        end
        PH_B7_GROUP: begin
          if (s.group_position < GROUP_LAST) begin
            s.group_position = s.group_position + 2'd1;
          end else begin
            s.group_position = 2'd0;
            s.bytes_left = {1'b0, tail};
            if (tail != 2'd0) begin
              s.phase = PH_B7_TAIL;
            end else begin
              s.groups_left = s.groups_left - 6'd1;
              s.phase = (s.groups_left == 6'd0) ? PH_OPCODE : PH_B7_GROUP;
            end
          end
        end
        PH_B7_TAIL: begin
          s.bytes_left = s.bytes_left - 3'd1;
          if (s.bytes_left == 3'd0) begin
            s.groups_left = s.groups_left - 6'd1;
            s.phase = (s.groups_left == 6'd0) ? PH_OPCODE : PH_B7_GROUP;
          end
        end
        default: begin
          s.phase = PH_START;
          s.first_block = 1'b1;
        end
      endcase
    end

    state_next = s;
    result = r;
  end

endmodule

[rtl/anim_script_command_delimiter.sv]
// an accepted beat is held in the input register, then classified into the result register when the output side is free
// throughput: one beat per cycle while out_ready does not stall the result register, parse state updated once per byte
// input register and result register decouple the two channels
// reset (rst, synchronous, active high): both registers empty, parser expects a
// header low byte or first opcode, stream_mode cleared to list mode
module anim_script_command_delimiter import ascd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  script_byte,
  input  logic        stream_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_class,
  output logic [15:0] anim_length,
  output logic        bad_opcode,
  output logic        anim_end,
  output logic        stream_end
);

  logic         stream_mode;
  logic         held_valid;
  logic [7:0]   held_byte;
  logic         held_start;
  parse_state_t state;
  parse_state_t state_next;
  result_t      result_next;
  result_t      result;
  logic         advance;

  assign cfg_ready = 1'b1;
  assign advance   = held_valid && (!out_valid || out_ready);
  assign in_ready  = !held_valid || advance;

  ascd_classify u_classify (
    .state        (state),
    .script_byte  (held_byte),
    .stream_start (held_start),
    .stream_mode  (stream_mode),
    .state_next   (state_next),
    .result       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_mode <= 1'b0;
      held_valid  <= 1'b0;
      out_valid   <= 1'b0;
      state       <= STATE_RESET;
    end else begin
      if (cfg_valid) stream_mode <= cfg_data;
      if (in_ready) held_valid <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte  <= script_byte;
      held_start <= stream_start;
    end
    if (advance) result <= result_next;
  end

  assign byte_class  = result.byte_class;
  assign anim_length = result.anim_length;
  assign bad_opcode  = result.bad_opcode;
  assign anim_end    = result.anim_end;
  assign stream_end  = result.stream_end;

  a_bad_is_opcode: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_opcode |-> byte_class == CL_OPCODE && anim_end)
    else $error("bad opcode flag on a non-opcode beat");

  a_len_only_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && anim_length != 16'd0 |-> byte_class == CL_HDR_HI)
    else $error("length reported outside a header high beat");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && result_next.stream_end |=> state.phase == PH_START && state.first_block)
    else $error("parser did not restart after stream end");

  a_end_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> byte_class == CL_TERM || byte_class == CL_PARAM)
    else $error("stream end on an unexpected class");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("parse state changed without a beat");

endmodule

[test/testbench.sv]
module testbench import ascd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 200;
  localparam int HOLD_CYCLES = 150;
  localparam result_t NO_WANT = '0;

  typedef struct {
    logic [7:0] b;
    logic       s;
    logic       typed;
    result_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  script_byte = 8'h00;
  logic        stream_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  byte_class;
  logic [15:0] anim_length;
  logic        bad_opcode;
  logic        anim_end;
  logic        stream_end;

  // parser shadow
  logic [3:0] ps_phase = PH_START;
  logic [5:0] ps_held = '0;
  logic [2:0] ps_bytes = '0;
  logic [5:0] ps_groups = '0;
  logic [1:0] ps_gpos = '0;
  logic [7:0] ps_hdr_lo = '0;
  logic       ps_first = 1'b1;
  logic       ps_mode = 1'b0;

  result_t  class_q[$];
  dir_row_t dir_tab [23];

  int err_count = 0;
  int bytes_in = 0;
  int results_ok = 0;
  int bad_seen = 0;
  int aend_seen = 0;
  int send_seen = 0;
  int burst_left = 0;
  bit tx_gaps = 1'b1;
  int rx_style = 0;
  int rx_tick = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  anim_script_command_delimiter DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .script_byte(script_byte),
    .stream_start(stream_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .byte_class(byte_class),
    .anim_length(anim_length),
    .bad_opcode(bad_opcode),
    .anim_end(anim_end),
    .stream_end(stream_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [2:0] tail_len(input logic [3:0] nib);
    return (nib >= 4'd3) ? 3'd3 : {1'b0, nib[1:0]};
  endfunction

  function automatic void close_group();
    ps_groups = ps_groups - 6'd1;
    ps_phase = (ps_groups == 6'd0) ? PH_OPCODE : PH_B7_GROUP;
  endfunction

  function automatic result_t classify_byte(input logic [7:0] b, input logic s);
    result_t    r;
    logic [2:0] n;
    r = NO_WANT;
    r.byte_class = CL_OPERAND;
    n = 3'd0;
    if (s) begin
      ps_phase = PH_START;
      ps_first = 1'b1;
    end
    if (ps_phase == PH_START && !(ps_mode && ps_first)) begin
      r.byte_class = CL_HDR_LO;
      ps_hdr_lo = b;
      ps_phase = PH_HDR_HI;
    end else if (ps_phase == PH_HDR_HI) begin
      if (!ps_mode && ps_hdr_lo == BYTE_FF && b == BYTE_FF) begin
        r.byte_class = CL_TERM;
        r.stream_end = 1'b1;
        ps_phase = PH_START;
        ps_first = 1'b1;
      end else begin
        r.byte_class = CL_HDR_HI;
        r.anim_length = {b, ps_hdr_lo};
        ps_phase = PH_OPCODE;
      end
    end else if (ps_phase == PH_START || ps_phase == PH_OPCODE) begin
      r.byte_class = CL_OPCODE;
      ps_phase = PH_OPCODE;
      if (b == BYTE_FF) begin
        r.byte_class = CL_TERM;
        r.anim_end = 1'b1;
        ps_phase = PH_START;
        ps_first = 1'b0;
      end else if (b[7]) begin
        ps_groups = b[5:0];
        if (ps_groups != 6'd0) begin
          ps_bytes = B7_HEAD_LEN;
          ps_phase = PH_B7_HEAD;
        end
      end else if (b[6]) begin
        ps_bytes = B6_OPERANDS;
        ps_phase = PH_OPERANDS;
      end else if (b[5:0] > FUNC_MAX) begin
        r.bad_opcode = 1'b1;
        r.anim_end = 1'b1;
        ps_phase = PH_START;
        ps_first = 1'b0;
      end else if (b[5:0] > FUNC_NO_ARGS) begin
        ps_held = b[5:0];
        ps_phase = PH_PARAM;
      end
    end else if (ps_phase == PH_PARAM) begin
      r.byte_class = CL_PARAM;
      case (ps_held)
        FN_06: n = b[7] ? 3'd3 : 3'd2;
        FN_09, FN_15: n = 3'd1;
        FN_0D, FN_0E: n = (b != 8'h00) ? 3'd1 : 3'd0;
        FN_0F: n = b[7] ? 3'd1 : 3'd2;
        FN_11: n = tail_len(b[3:0]);
        FN_13: n = b[7] ? 3'd0 : 3'd1;
        FN_14: n = 3'd4;
        default: n = 3'd0;
      endcase
      if (ps_held == FN_0B) begin
        ps_groups = {2'b00, b[3:0]};
        ps_phase = (ps_groups != 6'd0) ? PH_MANY : PH_OPCODE;
      end else if (ps_held == FN_16 && ps_mode && b == PARAM_END) begin
        r.anim_end = 1'b1;
        r.stream_end = 1'b1;
        ps_phase = PH_START;
        ps_first = 1'b1;
      end else begin
        ps_bytes = n;
        ps_phase = (n != 3'd0) ? PH_OPERANDS : PH_OPCODE;
      end
    end else if (ps_phase == PH_OPERANDS) begin
      ps_bytes = ps_bytes - 3'd1;
      if (ps_bytes == 3'd0) ps_phase = PH_OPCODE;
    end else if (ps_phase == PH_MANY) begin
      ps_groups = ps_groups - 6'd1;
      if (ps_groups == 6'd0) ps_phase = PH_OPCODE;
    end else if (ps_phase == PH_B7_HEAD) begin
      ps_bytes = ps_bytes - 3'd1;
      if (ps_bytes == 3'd0) begin
        ps_gpos = 2'd0;
        ps_phase = PH_B7_GROUP;
      end
    end else if (ps_phase == PH_B7_GROUP) begin
      if (ps_gpos != GROUP_LAST) begin
        ps_gpos = ps_gpos + 2'd1;
      end else begin
        ps_gpos = 2'd0;
        ps_bytes = tail_len(b[3:0]);
        if (ps_bytes != 3'd0) ps_phase = PH_B7_TAIL;
        else close_group();
      end
    end else if (ps_phase == PH_B7_TAIL) begin
      ps_bytes = ps_bytes - 3'd1;
      if (ps_bytes == 3'd0) close_group();
    end else begin
      ps_phase = PH_START;
      ps_first = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_opcode();
    int unsigned r;
    logic [5:0]  g;
    r = $urandom_range(0, 99);
    g = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
    if (r < 10) return BYTE_FF;
    if (r < 13) return {2'b00, 6'($urandom_range(FUNC_MAX + 1, 63))};
    if (r < 30) return {1'b1, 1'($urandom_range(0, 1)), g};
    if (r < 42) return {2'b01, 6'($urandom_range(0, 63))};
    if (r < 52) return {2'b00, FN_16};
    return {2'b00, 6'($urandom_range(0, FUNC_MAX))};
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic s, input logic typed,
                           input result_t want);
    result_t pred;
    if (tx_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    script_byte <= b;
    stream_start <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    pred = classify_byte(b, s);
    class_q.push_back(typed ? want : pred);
    bytes_in++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (class_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    ps_mode = m;
  endtask

  // result side: check each beat, then pick next ready
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got = {byte_class, anim_length, bad_opcode, anim_end, stream_end};
      if (class_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, got class %0d len %h flags %b%b%b",
                 $time, got.byte_class, got.anim_length, got.bad_opcode, got.anim_end,
                 got.stream_end);
      end else begin
        want = class_q.pop_front();
        if (got !== want) begin
          err_count++;
          $display("%0t: mismatch expected %0d/%h/%b%b%b got %0d/%h/%b%b%b",
                   $time, want.byte_class, want.anim_length, want.bad_opcode, want.anim_end,
                   want.stream_end, got.byte_class, got.anim_length, got.bad_opcode,
                   got.anim_end, got.stream_end);
        end else begin
          results_ok++;
        end
        if (got.bad_opcode) bad_seen++;
        if (got.anim_end) aend_seen++;
        if (got.stream_end) send_seen++;
      end
    end
    rx_tick++;
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_tick % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    logic       s;
    int unsigned r;
    dir_tab = '{
      '{8'h34, 1'b1, 1'b1, {CL_HDR_LO, 16'h0000, 3'b000}},
      '{8'h12, 1'b0, 1'b1, {CL_HDR_HI, 16'h1234, 3'b000}},
      '{8'h17, 1'b0, 1'b1, {CL_OPCODE, 16'h0000, 3'b110}},
      '{8'hFF, 1'b0, 1'b1, {CL_HDR_LO, 16'h0000, 3'b000}},
      '{8'hFF, 1'b0, 1'b1, {CL_TERM,   16'h0000, 3'b001}},
      '{8'h00, 1'b0, 1'b1, {CL_HDR_LO, 16'h0000, 3'b000}},
      '{8'hFF, 1'b0, 1'b1, {CL_HDR_HI, 16'hFF00, 3'b000}},
      '{8'h40, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h81, 1'b0, 1'b0, NO_WANT},
      '{8'h80, 1'b0, 1'b0, NO_WANT},
      '{8'h01, 1'b0, 1'b0, NO_WANT},
      '{8'h7F, 1'b0, 1'b0, NO_WANT},
      '{8'hFE, 1'b0, 1'b0, NO_WANT},
      '{8'h55, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h02, 1'b0, 1'b0, NO_WANT},
      '{8'hAA, 1'b0, 1'b0, NO_WANT},
      '{8'hBB, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b0, 1'b1, {CL_TERM,   16'h0000, 3'b010}}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_mode(1'b0);
    foreach (dir_tab[i])
      push_byte(dir_tab[i].b, dir_tab[i].s, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_mode(1'(ph % 2));
      rx_style = ph % 4;
      tx_gaps = (ph % 4 != 2);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (ph == 5 && i == 60) hold_asks++;
        if (ph == 3 && i == 100) drain();
        s = ($urandom_range(0, 99) == 0);
        r = $urandom_range(0, 99);
        if (r < 4) begin
          b = 8'($urandom_range(0, 255));
        end else if (s || ps_phase == PH_START) begin
          if (ps_mode && (s || ps_first))
            b = pick_opcode();
          else
            b = ($urandom_range(0, 5) == 0) ? BYTE_FF : 8'($urandom_range(0, 255));
        end else if (ps_phase == PH_HDR_HI) begin
          b = (ps_hdr_lo == BYTE_FF && $urandom_range(0, 2) != 0) ? BYTE_FF :
              8'($urandom_range(0, 255));
        end else if (ps_phase == PH_OPCODE) begin
          b = pick_opcode();
        end else if (ps_phase == PH_PARAM && ps_held == FN_16 && $urandom_range(0, 1) == 1) begin
          b = PARAM_END;
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        push_byte(b, s, 1'b0, NO_WANT);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d script bytes over list and shared mode, %0d results matched",
             bytes_in, results_ok);
    $display("seen %0d animation ends, %0d stream ends, %0d bad opcodes",
             aend_seen, send_seen, bad_seen);
    if (err_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
